FILE: rtl/kts_pkg.sv
`timescale 1ns / 1ps
package kts_pkg;

  localparam logic [31:0] NativeMagic = 32'h464b5845;
  localparam logic [29:0] NsPerSec    = 30'd1000000000;

  localparam logic [1:0] OP_PACKET = 2'd0;
  localparam logic [1:0] OP_NATIVE = 2'd1;
  localparam logic [1:0] OP_COMPAT = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNSUP   = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_STALE   = 2'd3;

  localparam logic [1:0] POS_NONE = 2'd0;
  localparam logic [1:0] POS_END4 = 2'd1;
  localparam logic [1:0] POS_END8 = 2'd2;

  localparam logic [1:0] REG_OFFSET_MODE = 2'd0;
  localparam logic [1:0] REG_COMPAT_RATE = 2'd1;
  localparam logic [1:0] REG_MAX_AGE     = 2'd2;
  localparam logic [1:0] REG_WINDOW      = 2'd3;

  typedef enum logic [1:0] {
    KIND_PACKET,
    KIND_NATIVE_KF,
    KIND_COMPAT_KF,
    KIND_COMPAT_BAD
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_MUL, S_DIV, S_DONE
  } state_e;

  typedef enum logic [1:0] {
    PASS_LEARN4, PASS_LEARN8, PASS_FINAL
  } pass_e;

  typedef struct packed {
    kind_e       kind;
    logic [62:0] capture_time_ns;
    logic [62:0] kf_utc_ns;
    logic [31:0] kf_counter;
    logic [31:0] kf_freq;
    logic [31:0] word_end4;
    logic [31:0] word_end8;
    logic        fcs_valid;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  offset_mode;
    logic [31:0] compat_tick_rate;
    logic [35:0] keyframe_max_age_ns;
    logic [31:0] match_window_ns;
  } cfg_t;

endpackage

FILE: rtl/keyframe_timestamp_reconstruct.sv
`timescale 1ns / 1ps
// keyframes and rejected keyframes raise tvalid in the cycle after the back end pops them
// packets: a stale packet is answered from the check state; others go through the multiply state,
// the 62-step serial divider and the done state, a learning packet twice (end4, then end8)
// the back end pops a new item only when idle and its result register is free or being read
// a two-entry queue lets the input side take items while the back end works
// reset (rst_ni, async, active low): reference and learned position cleared, registers to defaults
module keyframe_timestamp_reconstruct
  import kts_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // capture_time_ns, key version, key magic, kf_utc_ns, kf_counter, kf_freq,
  // skew numerator, skew_den, word_end4, word_end8, zero pad
  input  logic [359:0] s_axis_tdata,
  // opcode, fcs_valid
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // time_ns, zero pad
  output logic [63:0]  m_axis_tdata,
  // status, keyframe flag, offset_used
  output logic [4:0]   m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  cfg_t       cfg_q, cfg_d;
  logic       cfg_wr;
  logic       clear_learned;
  cmd_t       front_cmd;
  cmd_t       q_cmd;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  logic       push;
  logic [62:0] time_ns;

  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite && pready;
  assign clear_learned = cfg_wr && paddr[4:3] == REG_OFFSET_MODE;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (paddr[4:3])
        REG_OFFSET_MODE: cfg_d.offset_mode         = pwdata[1:0];
        REG_COMPAT_RATE: cfg_d.compat_tick_rate    = pwdata[31:0];
        REG_MAX_AGE:     cfg_d.keyframe_max_age_ns = pwdata[35:0];
        REG_WINDOW:      cfg_d.match_window_ns     = pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_OFFSET_MODE: prdata = {62'd0, cfg_q.offset_mode};
      REG_COMPAT_RATE: prdata = {32'd0, cfg_q.compat_tick_rate};
      REG_MAX_AGE:     prdata = {28'd0, cfg_q.keyframe_max_age_ns};
      REG_WINDOW:      prdata = {32'd0, cfg_q.match_window_ns};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset_mode         <= 2'd0;
      cfg_q.compat_tick_rate    <= 32'd1000000000;
      cfg_q.keyframe_max_age_ns <= 36'd5000000000;
      cfg_q.match_window_ns     <= 32'd10000000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  kts_front u_front (
    .opcode_i          (s_axis_tuser[1:0]),
    .capture_time_ns_i (s_axis_tdata[62:0]),
    .key_ver_i         (s_axis_tdata[70:63]),
    .key_magic_i       (s_axis_tdata[102:71]),
    .kf_utc_ns_i       (s_axis_tdata[165:103]),
    .kf_counter_i      (s_axis_tdata[197:166]),
    .kf_freq_i         (s_axis_tdata[229:198]),
    .skew_n_i          (s_axis_tdata[261:230]),
    .skew_den_i        (s_axis_tdata[293:262]),
    .word_end4_i       (s_axis_tdata[325:294]),
    .word_end8_i       (s_axis_tdata[357:326]),
    .fcs_valid_i       (s_axis_tuser[2]),
    .cmd_o             (front_cmd)
  );

  kts_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_cmd)
  );

  kts_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .clear_learned_i (clear_learned),
    .empty_i         (q_empty),
    .cmd_i           (q_cmd),
    .pop_o           (q_pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .status_o        (m_axis_tuser[1:0]),
    .time_ns_o       (time_ns),
    .key_flag_o      (m_axis_tuser[2]),
    .offset_used_o   (m_axis_tuser[4:3])
  );

  assign m_axis_tdata = {1'b0, time_ns};

endmodule

FILE: rtl/kts_front.sv
`timescale 1ns / 1ps
module kts_front
  import kts_pkg::*;
(
  input  logic [1:0]  opcode_i,
  input  logic [62:0] capture_time_ns_i,
  input  logic [7:0]  key_ver_i,
  input  logic [31:0] key_magic_i,
  input  logic [62:0] kf_utc_ns_i,
  input  logic [31:0] kf_counter_i,
  input  logic [31:0] kf_freq_i,
  input  logic [31:0] skew_n_i,
  input  logic [31:0] skew_den_i,
  input  logic [31:0] word_end4_i,
  input  logic [31:0] word_end8_i,
  input  logic        fcs_valid_i,
  output cmd_t        cmd_o
);

  logic native_ok;
  logic compat_ok;

  assign native_ok = (key_ver_i == 8'd1 && key_magic_i == NativeMagic) ||
                     (key_ver_i == 8'd0 && key_magic_i == 32'd1);
  assign compat_ok = (skew_n_i == 32'd1) && (skew_den_i == 32'd1);

  always_comb begin
    cmd_o.capture_time_ns = capture_time_ns_i;
    cmd_o.kf_utc_ns       = kf_utc_ns_i;
    cmd_o.kf_counter      = kf_counter_i;
    cmd_o.kf_freq         = kf_freq_i;
    cmd_o.word_end4       = word_end4_i;
    cmd_o.word_end8       = word_end8_i;
    cmd_o.fcs_valid       = fcs_valid_i;
    case (opcode_i)
      OP_NATIVE: cmd_o.kind = native_ok ? KIND_NATIVE_KF : KIND_PACKET;
      OP_COMPAT: cmd_o.kind = compat_ok ? KIND_COMPAT_KF : KIND_COMPAT_BAD;
      default:   cmd_o.kind = KIND_PACKET;
    endcase
  end

endmodule

FILE: rtl/kts_queue.sv
`timescale 1ns / 1ps
module kts_queue
  import kts_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t pop_data_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o     = count_q == 2'd2;
  assign empty_o    = count_q == 2'd0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");
`endif

endmodule

FILE: rtl/kts_back.sv
`timescale 1ns / 1ps
module kts_back
  import kts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        clear_learned_i,
  input  logic        empty_i,
  input  cmd_t        cmd_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [62:0] time_ns_o,
  output logic        key_flag_o,
  output logic [1:0]  offset_used_o
);

  state_e      state_q, state_d;
  pass_e       pass_q, pass_d;
  cmd_t        item_q, item_d;
  logic        neg_q, neg_d;
  logic [62:0] mag_q, mag_d;
  logic [31:0] word_q, word_d;
  logic [61:0] prod_q, prod_d;
  logic [31:0] rem_q, rem_d;
  logic [61:0] quot_q, quot_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [61:0] q4_q, q4_d;
  logic        m4_q, m4_d;
  logic [1:0]  pos_q, pos_d;

  logic [62:0] ref_utc_q, ref_utc_d;
  logic [31:0] ref_cnt_q, ref_cnt_d;
  logic [31:0] ref_freq_q, ref_freq_d;
  logic        ref_compat_q, ref_compat_d;
  logic [62:0] ref_cap_q, ref_cap_d;
  logic [1:0]  learned_q, learned_d;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  status_q, status_d;
  logic [62:0] time_q, time_d;
  logic        kf_q, kf_d;
  logic [1:0]  used_q, used_d;

  logic        out_free;
  logic        cap_lt;
  logic [62:0] cap_diff;
  logic        stale;
  logic [31:0] ticks;
  logic [32:0] shifted;
  logic        ge;
  logic [63:0] wdist;
  logic        hit;
  logic        load_out;
  logic [1:0]  out_status;
  logic [61:0] out_q;
  logic [1:0]  out_pos;
  logic [63:0] tsum;
  logic        mode_fixed;

  function automatic logic [31:0] elapsed(input logic [31:0] w, input logic [31:0] c,
                                           input logic compat);
    logic [30:0] t;
    logic [30:0] d;
    begin
      t = {w[31:8], w[6:0]};
      d = t - c[30:0];
      elapsed = compat ? {1'b0, d} : w - c;
    end
  endfunction

  assign out_free   = !out_valid_q || out_ready_i;
  assign pop_o      = state_q == S_IDLE && !empty_i && out_free;
  assign cap_lt     = item_q.capture_time_ns < ref_cap_q;
  assign cap_diff   = cap_lt ? ref_cap_q - item_q.capture_time_ns
                             : item_q.capture_time_ns - ref_cap_q;
  assign stale      = (!cap_lt && cap_diff > {27'd0, cfg_i.keyframe_max_age_ns}) ||
                      ref_freq_q == 32'd0;
  assign ticks      = elapsed(word_q, ref_cnt_q, ref_compat_q);
  assign shifted    = {rem_q, prod_q[61]};
  assign ge         = shifted >= {1'b0, ref_freq_q};
  assign wdist      = neg_q ? {2'b00, quot_q} + {1'b0, mag_q}
                    : ({1'b0, quot_q} >= mag_q ? {1'b0, {1'b0, quot_q} - mag_q}
                                               : {1'b0, mag_q - {1'b0, quot_q}});
  assign hit        = wdist < {32'd0, cfg_i.match_window_ns};
  assign mode_fixed = cfg_i.offset_mode == POS_END4 || cfg_i.offset_mode == POS_END8;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (pop_o && cmd_i.kind == KIND_PACKET) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stale) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL:   state_d = S_DIV;
      S_DIV: begin
        if (cnt_q == 6'd0) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (pass_q == PASS_LEARN4) begin
          state_d = S_MUL;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pass_d       = pass_q;
    item_d       = item_q;
    neg_d        = neg_q;
    mag_d        = mag_q;
    word_d       = word_q;
    prod_d       = prod_q;
    rem_d        = rem_q;
    quot_d       = quot_q;
    cnt_d        = cnt_q;
    q4_d         = q4_q;
    m4_d         = m4_q;
    pos_d        = pos_q;
    ref_utc_d    = ref_utc_q;
    ref_cnt_d    = ref_cnt_q;
    ref_freq_d   = ref_freq_q;
    ref_compat_d = ref_compat_q;
    ref_cap_d    = ref_cap_q;
    learned_d    = learned_q;
    load_out     = 1'b0;
    out_status   = ST_OK;
    out_q        = quot_q;
    out_pos      = pos_q;
    status_d     = status_q;
    time_d       = time_q;
    kf_d         = kf_q;
    used_d       = used_q;
    case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          item_d = cmd_i;
          case (cmd_i.kind)
            KIND_NATIVE_KF, KIND_COMPAT_KF: begin
              ref_utc_d    = cmd_i.kf_utc_ns;
              ref_cnt_d    = cmd_i.kf_counter;
              ref_compat_d = cmd_i.kind == KIND_COMPAT_KF;
              ref_freq_d   = (cmd_i.kind == KIND_COMPAT_KF) ? cfg_i.compat_tick_rate
                                                            : cmd_i.kf_freq;
              ref_cap_d    = cmd_i.capture_time_ns;
              status_d     = ST_OK;
              time_d       = cmd_i.kf_utc_ns;
              kf_d         = 1'b1;
              used_d       = POS_NONE;
            end
            KIND_COMPAT_BAD: begin
              status_d = ST_UNSUP;
              time_d   = '0;
              kf_d     = 1'b0;
              used_d   = POS_NONE;
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        neg_d = cap_lt;
        mag_d = cap_diff;
        if (stale) begin
          load_out   = 1'b1;
          out_status = ST_STALE;
        end else if (mode_fixed) begin
          pos_d  = cfg_i.offset_mode;
          pass_d = PASS_FINAL;
          word_d = (cfg_i.offset_mode == POS_END4) ? item_q.word_end4 : item_q.word_end8;
        end else if (learned_q != POS_NONE) begin
          pos_d  = learned_q;
          pass_d = PASS_FINAL;
          word_d = (learned_q == POS_END4) ? item_q.word_end4 : item_q.word_end8;
        end else begin
          pass_d = PASS_LEARN4;
          word_d = item_q.word_end4;
        end
      end
      S_MUL: begin
        prod_d = {30'd0, ticks} * {32'd0, NsPerSec};
        rem_d  = '0;
        quot_d = '0;
        cnt_d  = 6'd61;
      end
      S_DIV: begin
        // one restoring quotient bit per cycle
        rem_d  = ge ? 32'(shifted - {1'b0, ref_freq_q}) : shifted[31:0];
        prod_d = {prod_q[60:0], 1'b0};
        quot_d = {quot_q[60:0], ge};
        cnt_d  = cnt_q - 6'd1;
      end
      S_DONE: begin
        case (pass_q)
          PASS_LEARN4: begin
            q4_d   = quot_q;
            m4_d   = hit;
            pass_d = PASS_LEARN8;
            word_d = item_q.word_end8;
          end
          PASS_LEARN8: begin
            load_out = 1'b1;
            if (m4_q && !item_q.fcs_valid) begin
              learned_d = POS_END4;
              out_pos   = POS_END4;
              out_q     = q4_q;
            end else if (hit && item_q.fcs_valid) begin
              learned_d = POS_END8;
              out_pos   = POS_END8;
            end else begin
              out_status = ST_MISSING;
            end
          end
          default: load_out = 1'b1;
        endcase
      end
      default: ;
    endcase
    if (load_out) begin
      status_d = out_status;
      kf_d     = 1'b0;
      if (out_status == ST_OK) begin
        time_d = tsum[63] ? {63{1'b1}} : tsum[62:0];
        used_d = out_pos;
      end else begin
        time_d = '0;
        used_d = POS_NONE;
      end
    end
    if (clear_learned_i) begin
      learned_d = POS_NONE;
    end
  end

  assign tsum = {1'b0, ref_utc_q} + {2'b00, out_q};

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if ((pop_o && cmd_i.kind != KIND_PACKET) || load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    pass_q <= pass_d;
    item_q <= item_d;
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    word_q <= word_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    cnt_q  <= cnt_d;
    q4_q   <= q4_d;
    m4_q   <= m4_d;
    pos_q  <= pos_d;
    status_q <= status_d;
    time_q   <= time_d;
    kf_q     <= kf_d;
    used_q   <= used_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      ref_utc_q    <= '0;
      ref_cnt_q    <= '0;
      ref_freq_q   <= '0;
      ref_compat_q <= 1'b0;
      ref_cap_q    <= '0;
      learned_q    <= POS_NONE;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      ref_utc_q    <= ref_utc_d;
      ref_cnt_q    <= ref_cnt_d;
      ref_freq_q   <= ref_freq_d;
      ref_compat_q <= ref_compat_d;
      ref_cap_q    <= ref_cap_d;
      learned_q    <= learned_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign time_ns_o     = time_q;
  assign key_flag_o    = kf_q;
  assign offset_used_o = used_q;

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == S_IDLE) else $error("pop while busy");
  a_no_clobber: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> !out_valid_q) else $error("result overwrites pending result");
  a_kf_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kf_q |-> status_q == ST_OK && used_q == POS_NONE)
    else $error("keyframe result malformed");
`endif

endmodule

FILE: tb/sv/keyframe_timestamp_reconstruct_tb.sv
`timescale 1ns / 1ps
module keyframe_timestamp_reconstruct_tb;
  import kts_pkg::*;

  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned HoldCycles = 500;
  localparam longint unsigned Max63 = 64'h7fffffffffffffff;
  localparam longint unsigned NsSec = 64'd1000000000;

  typedef struct {
    logic [1:0]  op;
    logic [62:0] cap;
    logic [7:0]  ver;
    logic [31:0] magic;
    logic [62:0] utc;
    logic [31:0] cnt;
    logic [31:0] freq;
    logic [31:0] snum;
    logic [31:0] sden;
    logic [31:0] w4;
    logic [31:0] w8;
    logic        fcs;
  } frame_t;

  typedef struct {
    logic [1:0]  status;
    logic [62:0] time_ns;
    logic        kf;
    logic [1:0]  pos;
  } stamp_t;

  typedef struct {
    frame_t frame;
    bit     typed;
    stamp_t stamp;
  } dir_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [359:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic [4:0]   m_axis_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;

  keyframe_timestamp_reconstruct DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mirror of the block configuration and keyframe reference
  logic [1:0]      mode_q;
  longint unsigned compat_rate_q, max_age_q, window_q;
  longint unsigned kf_utc_q, kf_cnt_q, kf_freq_q, kf_cap_q;
  bit              kf_compat_q;
  logic [1:0]      learned_q;

  stamp_t      stamp_q[$];
  int unsigned err_cnt = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cnt = 0;
  bit          apb_busy = 1'b0;

  function automatic longint unsigned elapsed_ticks(logic [31:0] w);
    longint unsigned t;
    if (kf_compat_q) begin
      t = ((longint'(w) & 64'hffffff00) >> 1) + (longint'(w) & 64'h7f);
      return (t - (kf_cnt_q & 64'h7fffffff)) & 64'h7fffffff;
    end
    return (longint'(w) - kf_cnt_q) & 64'hffffffff;
  endfunction

  function automatic longint unsigned tick_ns(longint unsigned ticks);
    return ticks * NsSec / kf_freq_q;
  endfunction

  function automatic bit near(longint unsigned delta, bit neg, longint unsigned mag);
    longint unsigned d;
    if (neg) d = delta + mag;
    else d = delta >= mag ? delta - mag : mag - delta;
    return d < window_q;
  endfunction

  function automatic stamp_t predict_stamp(frame_t f);
    stamp_t r;
    bit neg, m4, m8;
    longint unsigned mag, t;
    logic [1:0] pos;
    r = '{ST_OK, '0, 1'b0, POS_NONE};
    if (f.op == OP_NATIVE &&
        ((f.ver == 8'd1 && f.magic == NativeMagic) || (f.ver == 8'd0 && f.magic == 32'd1))) begin
      kf_utc_q = f.utc; kf_cnt_q = f.cnt; kf_freq_q = f.freq;
      kf_compat_q = 1'b0; kf_cap_q = f.cap;
      r.time_ns = f.utc; r.kf = 1'b1;
      return r;
    end
    if (f.op == OP_COMPAT) begin
      if (f.snum == 32'd1 && f.sden == 32'd1) begin
        kf_utc_q = f.utc; kf_cnt_q = f.cnt; kf_freq_q = compat_rate_q;
        kf_compat_q = 1'b1; kf_cap_q = f.cap;
        r.time_ns = f.utc; r.kf = 1'b1;
      end else begin
        r.status = ST_UNSUP;
      end
      return r;
    end
    neg = f.cap < kf_cap_q;
    mag = neg ? kf_cap_q - f.cap : f.cap - kf_cap_q;
    if ((!neg && mag > max_age_q) || kf_freq_q == 0) begin
      r.status = ST_STALE;
      return r;
    end
    if (mode_q == POS_END4 || mode_q == POS_END8) begin
      pos = mode_q;
    end else begin
      if (learned_q == POS_NONE) begin
        m4 = near(tick_ns(elapsed_ticks(f.w4)), neg, mag);
        m8 = near(tick_ns(elapsed_ticks(f.w8)), neg, mag);
        if (m4 && !f.fcs) learned_q = POS_END4;
        else if (m8 && f.fcs) learned_q = POS_END8;
        else begin
          r.status = ST_MISSING;
          return r;
        end
      end
      pos = learned_q;
    end
    t = kf_utc_q + tick_ns(elapsed_ticks(pos == POS_END4 ? f.w4 : f.w8));
    r.time_ns = t > Max63 ? Max63 : t;
    r.pos = pos;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // receiver side: checks result beats and drives tready
  always @(posedge clk_i) begin
    stamp_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      if (stamp_q.size() == 0) begin
        report_mismatch("unexpected beat", m_axis_tdata, 0);
      end else begin
        e = stamp_q.pop_front();
        if (m_axis_tuser[1:0] !== e.status) report_mismatch("status", m_axis_tuser[1:0], e.status);
        if (m_axis_tdata[62:0] !== e.time_ns) report_mismatch("time_ns", m_axis_tdata[62:0], e.time_ns);
        if (m_axis_tuser[2] !== e.kf) report_mismatch("key flag", m_axis_tuser[2], e.kf);
        if (m_axis_tuser[4:3] !== e.pos) report_mismatch("offset_used", m_axis_tuser[4:3], e.pos);
      end
    end
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) || apb_busy)
      quiet_cnt <= 0;
    else
      quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic reg_write(logic [1:0] idx, longint unsigned val);
    apb_busy = 1'b1;
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_OFFSET_MODE: begin mode_q = val[1:0]; learned_q = POS_NONE; end
      REG_COMPAT_RATE: compat_rate_q = val & 64'hffffffff;
      REG_MAX_AGE:     max_age_q = val & 64'hfffffffff;
      REG_WINDOW:      window_q = val & 64'hffffffff;
      default: ;
    endcase
    apb_busy = 1'b0;
  endtask

  task automatic drain_results();
    if (s_axis_tvalid) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    while (stamp_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // hands one frame to the block; valid stays high for a back-to-back beat
  task automatic send_frame(frame_t f, bit typed, stamp_t want);
    stamp_t p;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= {f.fcs, f.op};
    s_axis_tdata <= {2'b00, f.w8, f.w4, f.sden, f.snum, f.freq, f.cnt, f.utc,
                     f.magic, f.ver, f.cap};
    do @(posedge clk_i); while (!s_axis_tready);
    p = predict_stamp(f);
    stamp_q.push_back(typed ? want : p);
  endtask

  function automatic logic [62:0] rand63();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [31:0] rand_freq();
    case ($urandom_range(5))
      0: return $urandom_range(1000);
      1: return 32'hffffffff;
      2: return 32'd0;
      default: return $urandom_range(32'hffffffff, 32'd1000);
    endcase
  endfunction

  // word that a frame captured gap_ns after the keyframe would carry
  function automatic logic [31:0] tick_word(longint unsigned gap_ns);
    longint unsigned ticks, t;
    ticks = gap_ns * kf_freq_q / NsSec;
    if (kf_compat_q) begin
      t = ((kf_cnt_q & 64'h7fffffff) + ticks) & 64'h7fffffff;
      return ((t & 64'h7fffff80) << 1) | (t & 64'h7f);
    end
    return kf_cnt_q + ticks;
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    longint unsigned delta;
    int unsigned pick;
    f = '{$urandom_range(1) ? OP_PACKET : OP_COMPAT, rand63(), $urandom(), $urandom(), rand63(),
          $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    pick = $urandom_range(99);
    if (pick < 14) begin
      f.op = OP_NATIVE;
      if ($urandom_range(5) != 0) begin
        f.ver = $urandom_range(1);
        f.magic = f.ver == 8'd1 ? NativeMagic : 32'd1;
      end
      f.freq = rand_freq();
      if ($urandom_range(3) != 0) f.utc = {1'b0, $urandom(), $urandom()} >> $urandom_range(40);
    end else if (pick < 24) begin
      f.op = OP_COMPAT;
      if ($urandom_range(4) != 0) begin f.snum = 32'd1; f.sden = 32'd1; end
      else if ($urandom_range(1)) f.snum = 32'd1;
    end else if (pick < 28) begin
      f.op = 2'd3;
    end else if (pick < 88) begin
      // well-formed packet near the last keyframe
      f.op = OP_PACKET;
      delta = $urandom_range(32'h00ffffff);
      if (max_age_q < delta) delta = max_age_q;
      f.cap = kf_cap_q + delta;
      if ($urandom_range(9) == 0 && kf_cap_q >= delta) f.cap = kf_cap_q - delta;
      f.fcs = $urandom_range(1);
      if (f.fcs) f.w8 = tick_word(f.cap >= kf_cap_q ? delta : 0);
      else f.w4 = tick_word(f.cap >= kf_cap_q ? delta : 0);
    end else begin
      f.op = $urandom_range(1) ? OP_PACKET : OP_NATIVE;
    end
    return f;
  endfunction

  dir_row_t dir_tab[14];

  initial begin
    frame_t f;
    stamp_t none;
    none = '{ST_OK, '0, 1'b0, POS_NONE};
    f = '{OP_PACKET, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0};
    // no keyframe seen yet: zero frequency
    dir_tab[0] = '{f, 1'b1, '{ST_STALE, '0, 1'b0, POS_NONE}};
    f.op = OP_COMPAT; f.snum = 32'd2; f.sden = 32'd1;
    dir_tab[1] = '{f, 1'b1, '{ST_UNSUP, '0, 1'b0, POS_NONE}};
    f.snum = 32'd1; f.utc = 63'd1000;
    dir_tab[2] = '{f, 1'b1, '{ST_OK, 63'd1000, 1'b1, POS_NONE}};
    f.op = OP_PACKET; f.cap = 63'd1000; f.w4 = 32'd2000; f.w8 = 32'hffffffff;
    dir_tab[3] = '{f, 1'b0, none};
    f.fcs = 1'b1; f.w4 = 32'hffffffff; f.w8 = 32'h000000ff;
    dir_tab[4] = '{f, 1'b0, none};
    f = '{OP_NATIVE, 63'd1000, 8'd1, NativeMagic, '1, '1, '1, '0, '0, '0, '0, 1'b0};
    dir_tab[5] = '{f, 1'b1, '{ST_OK, '1, 1'b1, POS_NONE}};
    // saturating sum
    f.op = OP_PACKET; f.w4 = 32'hfffffffe; f.w8 = 32'hfffffffe;
    dir_tab[6] = '{f, 1'b0, none};
    f = '{OP_NATIVE, 63'd1000, 8'd0, 32'd1, '0, '0, 32'd1, '1, '1, '1, '1, 1'b1};
    dir_tab[7] = '{f, 1'b1, '{ST_OK, '0, 1'b1, POS_NONE}};
    // bad magic falls through to a packet
    f.magic = NativeMagic; f.cap = 63'd1001; f.w4 = 32'd3; f.w8 = 32'd1;
    dir_tab[8] = '{f, 1'b0, none};
    f.op = 2'd3; f.cap = 63'd5;
    dir_tab[9] = '{f, 1'b0, none};
    f.op = OP_PACKET; f.cap = 63'd5000001001;
    dir_tab[10] = '{f, 1'b1, '{ST_STALE, '0, 1'b0, POS_NONE}};
    f.cap = 63'd5000001000;
    dir_tab[11] = '{f, 1'b0, none};
    f = '{OP_NATIVE, '1, 8'd1, NativeMagic, 63'd77, '0, '0, '0, '0, '0, '0, 1'b0};
    dir_tab[12] = '{f, 1'b1, '{ST_OK, 63'd77, 1'b1, POS_NONE}};
    f.op = OP_PACKET;
    dir_tab[13] = '{f, 1'b1, '{ST_STALE, '0, 1'b0, POS_NONE}};
  end

  initial begin
    mode_q = 2'd0; compat_rate_q = NsSec; max_age_q = 64'd5000000000;
    window_q = 64'd10000000; kf_utc_q = 0; kf_cnt_q = 0; kf_freq_q = 0;
    kf_compat_q = 1'b0; kf_cap_q = 0; learned_q = POS_NONE;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);
    foreach (dir_tab[i]) send_frame(dir_tab[i].frame, dir_tab[i].typed, dir_tab[i].stamp);
    drain_results();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          reg_write(REG_OFFSET_MODE, 2'd0); reg_write(REG_COMPAT_RATE, 64'd1);
          reg_write(REG_MAX_AGE, 64'hfffffffff); reg_write(REG_WINDOW, 64'hffffffff);
        end
        1: begin
          reg_write(REG_OFFSET_MODE, 2'd1); reg_write(REG_COMPAT_RATE, 64'hffffffff);
          reg_write(REG_MAX_AGE, 64'd0); reg_write(REG_WINDOW, 64'd0);
        end
        2: begin
          reg_write(REG_OFFSET_MODE, 2'd2); reg_write(REG_COMPAT_RATE, NsSec);
          reg_write(REG_MAX_AGE, 64'd5000000000); reg_write(REG_WINDOW, 64'd10000000);
        end
        3: begin
          reg_write(REG_OFFSET_MODE, 2'd3); reg_write(REG_COMPAT_RATE, $urandom());
          reg_write(REG_WINDOW, $urandom_range(32'h0fffffff));
        end
        default: begin
          reg_write(REG_OFFSET_MODE, 2'd0); reg_write(REG_COMPAT_RATE, $urandom_range(32'hffffffff, 1));
          reg_write(REG_MAX_AGE, {$urandom_range(15), $urandom()});
          reg_write(REG_WINDOW, 64'd10000000);
        end
      endcase
      for (int n = 0; n < 67; n++) begin
        if (phase < 2) begin tx_idle_pct = 6; rx_idle_pct = 58; end
        else if (phase < 4) begin tx_idle_pct = 58; rx_idle_pct = 6; end
        else begin tx_idle_pct = 0; rx_idle_pct = 0; end
        // long receiver stall while frames keep coming
        if (phase == 4 && n == 10) hold_req++;
        send_frame(random_frame(), 1'b0, '{ST_OK, '0, 1'b0, POS_NONE});
      end
      drain_results();
    end

    repeat (200) @(posedge clk_i);
    if (err_cnt == 0 && stamp_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
